// ----- design/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants of the clause satisfaction counter
// Field widths of the stream payloads and the request kind encoding.
// ----------------------------------------------------------------------------
package scc_pkg;

  // Payload field widths
  localparam int unsigned LIT_W      = 8;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned ASSIGN_W   = 64;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned S_TDATA_W  = 104;
  localparam int unsigned M_TDATA_W  = 16;

  // Request kind carried in tuser
  typedef enum logic [0:0] {
    REQ_LOAD = 1'b0,
    REQ_EVAL = 1'b1
  } req_e;

endpackage

// ----- design/scc_clause_eval.sv -----
// ----------------------------------------------------------------------------
// scc_clause_eval: tests one stored clause against a variable assignment
// A clause is satisfied when any of its literals is true. A literal of zero
// or with a magnitude above NUM_VARS is never true.
// ----------------------------------------------------------------------------
module scc_clause_eval import scc_pkg::*; #(
  parameter int unsigned NUM_VARS        = 64,
  parameter int unsigned LITS_PER_CLAUSE = 3
) (
  input  logic [LITS_PER_CLAUSE*LIT_W-1:0] clause_i,
  input  logic [ASSIGN_W-1:0]              assignment_i,
  output logic                             sat_o
);

  logic [LITS_PER_CLAUSE-1:0] lit_true;

  // One literal test per slot
  for (genvar k = 0; k < LITS_PER_CLAUSE; k++) begin : g_lit
    logic [LIT_W-1:0] lit;
    logic [LIT_W-1:0] mag;
    logic             in_range;
    logic [5:0]       var_idx;
    logic             var_val;

    assign lit      = clause_i[k*LIT_W +: LIT_W];
    // two's complement magnitude; -128 comes out as 128 and is out of range
    assign mag      = lit[LIT_W-1] ? (~lit + LIT_W'(1)) : lit;
    assign in_range = (mag != '0) && (32'(mag) <= NUM_VARS);
    assign var_idx  = 6'(mag - LIT_W'(1));
    assign var_val  = assignment_i[var_idx];
    assign lit_true[k] = in_range && (var_val ^ lit[LIT_W-1]);
  end

  assign sat_o = |lit_true;

endmodule

// ----- design/sat_clause_counter.sv -----
// ----------------------------------------------------------------------------
// sat_clause_counter: 3-SAT clause table with satisfaction count
// A load transaction writes one clause into the table and returns a zero
// result in the next cycle. An evaluate transaction reads clause entries
// 0 .. n-1, n = min(num_clauses, MAX_CLAUSES), one per cycle from the clause
// memory (one write, one read port) and presents its count after the last
// entry, or in the next cycle when n is zero. One item is processed at a
// time; a new item is taken once the block is idle and the output register
// is free or being drained. The clause memory needs no clearing after reset:
// entries must be loaded before they are counted.
// ----------------------------------------------------------------------------
module sat_clause_counter import scc_pkg::*; #(
  parameter int unsigned MAX_CLAUSES     = 512,
  parameter int unsigned NUM_VARS        = 64,
  parameter int unsigned LITS_PER_CLAUSE = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration: num_clauses
  input  logic                 cfg_we_i,
  input  logic [COUNT_W-1:0]   cfg_wdata_i,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // clause_index[8:0], lit_first[16:9], lit_second[24:17], lit_third[32:25],
  // assignment[96:33], zero fill[103:97]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // req_type[0]
  input  logic [0:0]           s_axis_tuser,
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // sat_count[9:0], all_sat[10], zero fill[15:11]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned ADDR_W  = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_CLAUSES + 1);
  localparam int unsigned ENTRY_W = LITS_PER_CLAUSE * LIT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN
  } state_e;

  // Input field unpacking
  logic [IDX_W-1:0]    in_idx;
  logic [3*LIT_W-1:0]  in_lits;
  logic [ASSIGN_W-1:0] in_assign;
  req_e                in_req;

  assign in_idx    = s_axis_tdata[8:0];
  assign in_lits   = s_axis_tdata[32:9];
  assign in_assign = s_axis_tdata[96:33];
  assign in_req    = req_e'(s_axis_tuser[0]);

  // Configuration register
  logic [COUNT_W-1:0] num_clauses_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_clauses_q <= '0;
    end else if (cfg_we_i) begin
      num_clauses_q <= cfg_wdata_i;
    end
  end

  // Control and datapath registers
  state_e              state_q;
  logic                m_valid_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic                out_all_q;
  logic [CNT_W-1:0]    rd_ptr_q;
  logic [CNT_W-1:0]    n_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                rd_vld_q;
  logic                rd_last_q;
  logic [ASSIGN_W-1:0] assign_q;

  logic                in_fire;
  logic                out_free;
  logic                out_load;
  logic                mem_we;
  logic                mem_re;
  logic [CNT_W-1:0]    n_clamped;
  logic [ENTRY_W-1:0]  rdata_q;
  logic                clause_sat;
  logic [CNT_W-1:0]    cnt_sum;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign mem_we        = in_fire && (in_req == REQ_LOAD) && (32'(in_idx) < MAX_CLAUSES);
  assign mem_re        = (state_q == S_READ);

  // Count limit: entries beyond the table are not counted
  assign n_clamped = (32'(num_clauses_q) > MAX_CLAUSES) ? CNT_W'(MAX_CLAUSES)
                                                        : CNT_W'(num_clauses_q);

  // Result register takes a value on a load, an empty count or the last clause
  assign out_load = (in_fire && ((in_req == REQ_LOAD) || (n_clamped == '0)))
                 || (rd_vld_q && rd_last_q);

  // Clause memory: one write port for loads, one read per cycle when counting
  logic [ENTRY_W-1:0] clause_mem [MAX_CLAUSES];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      clause_mem[ADDR_W'(in_idx)] <= in_lits[ENTRY_W-1:0];
    end
    if (mem_re) begin
      rdata_q <= clause_mem[rd_ptr_q[ADDR_W-1:0]];
    end
  end

  scc_clause_eval #(
    .NUM_VARS        (NUM_VARS),
    .LITS_PER_CLAUSE (LITS_PER_CLAUSE)
  ) u_eval (
    .clause_i     (rdata_q),
    .assignment_i (assign_q),
    .sat_o        (clause_sat)
  );

  assign cnt_sum = cnt_q + CNT_W'(clause_sat);

  // Sequencer: accept, walk the table, accumulate, present result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      m_valid_q   <= 1'b0;
      out_count_q <= '0;
      out_all_q   <= 1'b0;
      rd_ptr_q    <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      assign_q    <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && !out_load) begin
        m_valid_q <= 1'b0;
      end

      // per-clause accumulation from the registered read data
      rd_vld_q <= mem_re;
      if (rd_vld_q) begin
        cnt_q <= cnt_sum;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_req == REQ_LOAD) begin
              m_valid_q   <= 1'b1;
              out_count_q <= '0;
              out_all_q   <= 1'b0;
            end else if (n_clamped == '0) begin
              m_valid_q   <= 1'b1;
              out_count_q <= '0;
              out_all_q   <= 1'b1;
            end else begin
              state_q   <= S_READ;
              n_q       <= n_clamped;
              rd_ptr_q  <= '0;
              cnt_q     <= '0;
              assign_q  <= in_assign;
            end
          end
        end
        S_READ: begin
          rd_ptr_q  <= rd_ptr_q + CNT_W'(1);
          rd_last_q <= (rd_ptr_q + CNT_W'(1)) == n_q;
          if ((rd_ptr_q + CNT_W'(1)) == n_q) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (rd_vld_q && rd_last_q) begin
            m_valid_q   <= 1'b1;
            out_count_q <= COUNT_W'(cnt_sum);
            out_all_q   <= (cnt_sum == n_q);
            rd_last_q   <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - COUNT_W - 1)'(0), out_all_q, out_count_q};

`ifndef SYNTHESIS
  // A new result never overwrites one that is still waiting
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register overwritten before transfer");

  // The table is never written while a count is in progress
  a_no_write_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !mem_we)
    else $error("clause write during evaluation");

  // The last clause read lands only after issuing has stopped
  a_last_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && rd_last_q) |-> (state_q == S_DRAIN))
    else $error("last clause data outside drain state");

  // The running count never exceeds the number of clauses walked
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (cnt_q <= rd_ptr_q) && (rd_ptr_q <= n_q))
    else $error("clause count or read pointer out of bounds");

  // Entering the walk always starts from a non-empty range
  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_READ) |-> (n_q != '0) && (rd_ptr_q == '0))
    else $error("table walk started on an empty range");
`endif

endmodule
